// ===== rtl/lfp_pkg.sv =====
// Shared types, constants and the CRC-8 byte update for the lidar frame parser.
// Used by lfp_front, lfp_queue, lfp_back and lidar_frame_parser_crc8.
package lfp_pkg;

  // Frame geometry
  localparam int POINTS_PER_FRAME = 12;
  localparam int FRAME_BYTES      = 47;
  localparam int PT_IDX_W         = $clog2(POINTS_PER_FRAME);
  localparam int BYTE_CNT_W       = 6;
  localparam int MEM_ADDR_W       = PT_IDX_W + 1;
  localparam int MEM_DEPTH        = 2 ** MEM_ADDR_W;
  localparam int Q_DEPTH          = 2;

  // Byte positions inside a frame
  localparam logic [BYTE_CNT_W-1:0] POS_HUNT     = 6'd0;
  localparam logic [BYTE_CNT_W-1:0] POS_VER      = 6'd1;
  localparam logic [BYTE_CNT_W-1:0] POS_BODY     = 6'd2;
  localparam logic [BYTE_CNT_W-1:0] POS_START_LO = 6'd4;
  localparam logic [BYTE_CNT_W-1:0] POS_START_HI = 6'd5;
  localparam logic [BYTE_CNT_W-1:0] POS_PT_BASE  = 6'd6;
  localparam logic [BYTE_CNT_W-1:0] POS_END_LO   = 6'd42;
  localparam logic [BYTE_CNT_W-1:0] POS_END_HI   = 6'd43;
  localparam logic [BYTE_CNT_W-1:0] POS_CRC      = 6'(FRAME_BYTES - 1);

  // Sub-byte position within one point record
  localparam logic [1:0] SUB_DIST_LO = 2'd0;
  localparam logic [1:0] SUB_DIST_HI = 2'd1;
  localparam logic [1:0] SUB_INTENS  = 2'd2;

  localparam logic [PT_IDX_W-1:0] LAST_PT = PT_IDX_W'(POINTS_PER_FRAME - 1);

  // Protocol bytes
  localparam logic [7:0] HDR_BYTE = 8'h54;
  localparam logic [7:0] VER_BYTE = 8'h2C;
  localparam logic [7:0] CRC_POLY = 8'h4D;

  // Angle arithmetic
  localparam logic [16:0] FULL_TURN = 17'd36000;
  localparam logic [16:0] TWO_TURNS = 17'd72000;
  // ceil(2^20 / 11): exact quotient for dividends below 2^16
  localparam logic [16:0] RECIP11   = 17'd95326;
  localparam int          RECIP11_SH = 20;
  // ceil(2^19 / 100): exact quotient for dividends below 36000
  localparam logic [12:0] RECIP100  = 13'd5243;
  localparam int          RECIP100_SH = 19;

  // Descriptor of one checked frame, handed from front to back
  typedef struct packed {
    logic        bank;
    logic [15:0] start_ang;
    logic [15:0] end_ang;
  } lfp_desc_t;

  // Point store write port
  typedef struct packed {
    logic                  we;
    logic [MEM_ADDR_W-1:0] addr;
    logic [23:0]           data;
  } lfp_wr_t;

  // CRC-8, MSB first, no reflection
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/lfp_front.sv =====
// Front end: header hunt, CRC-8 check, angle capture and point store writes.
// Depends on lfp_pkg; pushes one descriptor per good frame.
module lfp_front
  import lfp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      byte_accept,
  input  logic [7:0] rx_byte,
  output lfp_wr_t   wr,
  output logic      push,
  output lfp_desc_t push_desc
);

  logic [BYTE_CNT_W-1:0] count_r, count_nxt;
  logic [7:0]            crc_r, crc_nxt;
  logic [1:0]            sub_r, sub_nxt;
  logic [PT_IDX_W-1:0]   idx_r, idx_nxt;
  logic [15:0]           hold_r, hold_nxt;
  logic [15:0]           start_r, start_nxt;
  logic [15:0]           end_r, end_nxt;
  logic                  wbank_r;

  // Byte classification and frame assembly
  always_comb begin
    count_nxt = count_r;
    crc_nxt   = crc_r;
    sub_nxt   = sub_r;
    idx_nxt   = idx_r;
    hold_nxt  = hold_r;
    start_nxt = start_r;
    end_nxt   = end_r;
    push      = 1'b0;
    wr.we     = 1'b0;
    wr.addr   = {wbank_r, idx_r};
    wr.data   = {rx_byte, hold_r};
    if (byte_accept) begin
      if (count_r == POS_HUNT || (count_r == POS_VER && rx_byte != VER_BYTE)) begin
        // hunt; a bad version byte is retried as a header
        if (rx_byte == HDR_BYTE) begin
          count_nxt = POS_VER;
          crc_nxt   = crc8_feed(8'h00, rx_byte);
        end else begin
          count_nxt = POS_HUNT;
          crc_nxt   = 8'h00;
        end
      end else if (count_r == POS_VER) begin
        count_nxt = POS_BODY;
        crc_nxt   = crc8_feed(crc_r, rx_byte);
        sub_nxt   = SUB_DIST_LO;
        idx_nxt   = '0;
      end else if (count_r < POS_CRC) begin
        count_nxt = count_r + 6'd1;
        crc_nxt   = crc8_feed(crc_r, rx_byte);
        if (count_r == POS_START_LO) begin
          start_nxt[7:0] = rx_byte;
        end else if (count_r == POS_START_HI) begin
          start_nxt[15:8] = rx_byte;
        end else if (count_r >= POS_PT_BASE && count_r < POS_END_LO) begin
          case (sub_r)
            SUB_DIST_LO: begin
              hold_nxt[7:0] = rx_byte;
              sub_nxt       = SUB_DIST_HI;
            end
            SUB_DIST_HI: begin
              hold_nxt[15:8] = rx_byte;
              sub_nxt        = SUB_INTENS;
            end
            default: begin
              wr.we   = 1'b1;
              sub_nxt = SUB_DIST_LO;
              idx_nxt = idx_r + PT_IDX_W'(1);
            end
          endcase
        end else if (count_r == POS_END_LO) begin
          end_nxt[7:0] = rx_byte;
        end else if (count_r == POS_END_HI) begin
          end_nxt[15:8] = rx_byte;
        end
      end else begin
        // CRC byte: a match hands the frame to the back end
        push      = (crc_r == rx_byte);
        count_nxt = POS_HUNT;
        crc_nxt   = 8'h00;
      end
    end
  end

  assign push_desc.bank      = wbank_r;
  assign push_desc.start_ang = start_r;
  assign push_desc.end_ang   = end_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= POS_HUNT;
      crc_r   <= 8'h00;
      wbank_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
      if (push) begin
        wbank_r <= ~wbank_r;
      end
    end
  end

  // Frame payload holding registers
  always_ff @(posedge clk) begin
    sub_r   <= sub_nxt;
    idx_r   <= idx_nxt;
    hold_r  <= hold_nxt;
    start_r <= start_nxt;
    end_r   <= end_nxt;
  end

endmodule

// ===== rtl/lfp_queue.sv =====
// Two-entry descriptor queue between the front and back ends.
// Depends on lfp_pkg for the descriptor type and depth.
module lfp_queue
  import lfp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  lfp_desc_t push_desc,
  input  logic      pop,
  output logic      head_valid,
  output lfp_desc_t head_desc,
  output logic      full
);

  localparam int PTR_W = $clog2(Q_DEPTH);

  lfp_desc_t          entry_r [Q_DEPTH];
  logic [PTR_W-1:0]   wptr_r;
  logic [PTR_W-1:0]   rptr_r;
  logic [PTR_W:0]     cnt_r;

  assign head_valid = (cnt_r != '0);
  assign full       = (cnt_r == (PTR_W + 1)'(Q_DEPTH));
  assign head_desc  = entry_r[rptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + PTR_W'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (PTR_W + 1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (PTR_W + 1)'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= push_desc;
    end
  end

endmodule

// ===== rtl/lfp_back.sv =====
// Back end: double-banked point store and the per-point angle sequencer.
// Depends on lfp_pkg; consumes descriptors and drives the result channel.
module lfp_back
  import lfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  lfp_wr_t     wr,
  input  logic        head_valid,
  input  lfp_desc_t   head_desc,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  out_degree,
  output logic [15:0] out_distance,
  output logic [7:0]  out_intensity,
  output logic        out_point_valid,
  output logic        out_last
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_STEP = 6'b000100,
    S_READ = 6'b001000,
    S_CALC = 6'b010000,
    S_OUT  = 6'b100000
  } back_state_t;

  back_state_t         state_r, state_nxt;
  logic [23:0]         mem_r [MEM_DEPTH];
  logic [23:0]         rd_data_r;
  logic [16:0]         diff_abs_r;
  logic                neg_r;
  logic [33:0]         qprod_r;
  logic signed [17:0]  step_r;
  logic signed [17:0]  ang_r;
  logic [15:0]         cm_r;
  logic [28:0]         dprod_r;
  logic [PT_IDX_W-1:0] idx_r;
  logic                out_valid_r;
  logic [15:0]         out_dist_r;
  logic [7:0]          out_int_r;
  logic                out_pv_r;
  logic                out_last_r;

  logic [16:0]         end_adj;
  logic signed [17:0]  diff;
  logic [12:0]         quot;
  logic [16:0]         ang_u;
  logic [16:0]         ang_mod;

  // Span from start to end, unwrapped past a full turn
  always_comb begin
    if (head_desc.end_ang < head_desc.start_ang) begin
      end_adj = {1'b0, head_desc.end_ang} + FULL_TURN;
    end else begin
      end_adj = {1'b0, head_desc.end_ang};
    end
    diff = $signed({1'b0, end_adj}) - $signed({2'b00, head_desc.start_ang});
  end

  assign quot = qprod_r[RECIP11_SH+12:RECIP11_SH];

  // Angle reduction; the angle stays below three full turns
  always_comb begin
    ang_u = ang_r[16:0];
    if (ang_u >= TWO_TURNS) begin
      ang_mod = ang_u - TWO_TURNS;
    end else if (ang_u >= FULL_TURN) begin
      ang_mod = ang_u - FULL_TURN;
    end else begin
      ang_mod = ang_u;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    case (state_r)
      S_IDLE: if (head_valid) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_STEP;
      S_STEP: state_nxt = S_READ;
      S_READ: state_nxt = S_CALC;
      S_CALC: state_nxt = S_OUT;
      S_OUT: begin
        if (!out_stall) begin
          if (idx_r == LAST_PT) begin
            pop       = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CALC) begin
        out_valid_r <= 1'b1;
      end else if (state_r == S_OUT && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Point store: written by the front end, read one point at a time
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem_r[wr.addr] <= wr.data;
    end
    if (state_r == S_READ) begin
      rd_data_r <= mem_r[{head_desc.bank, idx_r}];
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        neg_r      <= diff[17];
        diff_abs_r <= diff[17] ? 17'(-diff) : diff[16:0];
      end
      S_MUL: begin
        qprod_r <= diff_abs_r * RECIP11;
      end
      S_STEP: begin
        step_r <= neg_r ? -$signed({5'b00000, quot}) : $signed({5'b00000, quot});
        ang_r  <= $signed({2'b00, head_desc.start_ang});
        idx_r  <= '0;
      end
      S_READ: begin
        cm_r <= ang_mod[15:0];
      end
      S_CALC: begin
        dprod_r    <= cm_r * RECIP100;
        out_dist_r <= rd_data_r[15:0];
        out_int_r  <= rd_data_r[23:16];
        out_pv_r   <= (rd_data_r[15:0] != 16'h0000);
        out_last_r <= (idx_r == LAST_PT);
      end
      S_OUT: begin
        if (!out_stall) begin
          ang_r <= ang_r + step_r;
          idx_r <= idx_r + PT_IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_degree      = dprod_r[RECIP100_SH+8:RECIP100_SH];
  assign out_distance    = out_dist_r;
  assign out_intensity   = out_int_r;
  assign out_point_valid = out_pv_r;
  assign out_last        = out_last_r;

endmodule

// ===== rtl/lidar_frame_parser_crc8.sv =====
// Top level of the lidar frame parser: front end, descriptor queue, back end.
// Depends on lfp_pkg, lfp_front, lfp_queue and lfp_back.
//
// Usage:
//   Input channel (in_valid / in_stall / in_rx_byte) takes one serial byte
//   per transaction. The front end hunts for the 0x54 0x2C header, collects
//   a 47-byte frame and checks CRC-8 over the first 46 bytes.
//   Result channel (out_valid / out_stall / out_*) gives 12 point
//   transactions per good frame, out_last on the twelfth; a bad frame gives
//   none.
//   With the back end idle, a good frame's descriptor enters the queue as its
//   CRC byte is taken; the back end then passes S_MUL and S_STEP, and each
//   point passes S_READ, S_CALC and S_OUT (out_valid high, held by any
//   output stall), the per-point read / reduce / scale sequence. Input bytes
//   are taken one per cycle while in_stall is low. A two-entry queue with a
//   two-bank point store lets a new frame arrive while the previous one
//   drains; in_stall rises only while both banks hold frames not yet fully
//   taken. A stalled receiver holds the current point and its output
//   registers. Reset (rst_n low, synchronous) returns to header hunting and
//   empties the queue; no clearing pass is needed.
module lidar_frame_parser_crc8
  import lfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  out_degree,
  output logic [15:0] out_distance,
  output logic [7:0]  out_intensity,
  output logic        out_point_valid,
  output logic        out_last
);

  lfp_wr_t   wr;
  lfp_desc_t push_desc;
  lfp_desc_t head_desc;
  logic      push;
  logic      pop;
  logic      head_valid;
  logic      q_full;
  logic      byte_accept;

  assign in_stall    = q_full;
  assign byte_accept = in_valid && !q_full;

  lfp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_accept (byte_accept),
    .rx_byte     (in_rx_byte),
    .wr          (wr),
    .push        (push),
    .push_desc   (push_desc)
  );

  lfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .full       (q_full)
  );

  lfp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .wr              (wr),
    .head_valid      (head_valid),
    .head_desc       (head_desc),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_degree      (out_degree),
    .out_distance    (out_distance),
    .out_intensity   (out_intensity),
    .out_point_valid (out_point_valid),
    .out_last        (out_last)
  );

endmodule

// ===== verif/lidar_frame_parser_crc8_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for lidar_frame_parser_crc8: frame-level byte driver,
// point predictor/scoreboard class and random flow control. Depends on lfp_pkg.
module lidar_frame_parser_crc8_test;
  import lfp_pkg::*;

  localparam int BYTE_TARGET  = 470;
  localparam int PHASE_BYTES  = 40;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 500000;

  typedef enum int {FILL_ZERO, FILL_MAX, FILL_MIXED} fill_t;
  typedef enum int {PH_FLOW, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} phase_t;

  // One point transaction on the result channel
  typedef struct packed {
    logic [8:0]  degree;
    logic [15:0] distance;
    logic [7:0]  intensity;
    logic        point_valid;
    logic        last;
  } point_t;

  // Tracks the parser state and holds the points each good frame should give
  class frame_point_tracker;
    logic [5:0]  byte_pos;
    logic [7:0]  crc_acc;
    logic [15:0] start_ang;
    logic [15:0] end_ang;
    logic [15:0] dist_mem [POINTS_PER_FRAME];
    logic [7:0]  intens_mem [POINTS_PER_FRAME];
    point_t      expected_points [$];
    int          errors;

    function new();
      byte_pos = '0;
      crc_acc  = '0;
      errors   = 0;
    endfunction

    // CRC-8 byte update, MSB first
    function logic [7:0] crc_step(logic [7:0] crc, logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
        c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
    endfunction

    task flag(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function int pending();
      return expected_points.size();
    endfunction

    // Start over; a header byte starts a new frame right away
    function void rehunt(logic [7:0] b);
      byte_pos = '0;
      crc_acc  = '0;
      if (b == HDR_BYTE) begin
        crc_acc  = crc_step(8'h00, b);
        byte_pos = 6'd1;
      end
    endfunction

    function void keep_byte(logic [5:0] pos, logic [7:0] b);
      int rel;
      rel = int'(pos) - int'(POS_PT_BASE);
      if (pos == POS_START_LO) begin
        start_ang[7:0] = b;
      end else if (pos == POS_START_HI) begin
        start_ang[15:8] = b;
      end else if (pos >= POS_PT_BASE && pos < POS_END_LO) begin
        case (rel % 3)
          SUB_DIST_LO: dist_mem[rel / 3][7:0]  = b;
          SUB_DIST_HI: dist_mem[rel / 3][15:8] = b;
          default:     intens_mem[rel / 3]     = b;
        endcase
      end else if (pos == POS_END_LO) begin
        end_ang[7:0] = b;
      end else if (pos == POS_END_HI) begin
        end_ang[15:8] = b;
      end
    endfunction

    // Angle interpolation across the frame, wrapped to one turn
    function void queue_points();
      int     s, e, stp, c, cm;
      point_t p;
      s = int'(start_ang);
      e = int'(end_ang);
      if (e < s) e += 36000;
      stp = (e - s) / (POINTS_PER_FRAME - 1);
      for (int i = 0; i < POINTS_PER_FRAME; i++) begin
        c  = s + stp * i;
        cm = c % 36000;
        if (cm < 0) cm += 36000;
        p.degree      = 9'(cm / 100);
        p.distance    = dist_mem[i];
        p.intensity   = intens_mem[i];
        p.point_valid = (dist_mem[i] != 16'h0000);
        p.last        = (i == POINTS_PER_FRAME - 1);
        expected_points.push_back(p);
      end
    endfunction

    // Note one accepted input transaction
    function void take_byte(logic [7:0] b);
      if (byte_pos == POS_HUNT) begin
        rehunt(b);
      end else if (byte_pos == POS_VER) begin
        if (b == VER_BYTE) begin
          crc_acc  = crc_step(crc_acc, b);
          byte_pos = POS_BODY;
        end else begin
          rehunt(b);
        end
      end else if (byte_pos < POS_CRC) begin
        keep_byte(byte_pos, b);
        crc_acc  = crc_step(crc_acc, b);
        byte_pos = byte_pos + 6'd1;
      end else begin
        if (crc_acc == b) queue_points();
        byte_pos = '0;
        crc_acc  = '0;
      end
    endfunction

    // Compare one accepted result transaction with the oldest expected point
    task check_point(point_t got);
      point_t want;
      if (expected_points.size() == 0) begin
        flag($sformatf("unexpected point deg=%0d dist=%0d", got.degree, got.distance));
        return;
      end
      want = expected_points.pop_front();
      if (got.degree != want.degree)
        flag($sformatf("degree %0d, want %0d", got.degree, want.degree));
      if (got.distance != want.distance)
        flag($sformatf("distance %0d, want %0d", got.distance, want.distance));
      if (got.intensity != want.intensity)
        flag($sformatf("intensity %0d, want %0d", got.intensity, want.intensity));
      if (got.point_valid != want.point_valid)
        flag($sformatf("point_valid %0b, want %0b", got.point_valid, want.point_valid));
      if (got.last != want.last)
        flag($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [8:0]  out_degree;
  logic [15:0] out_distance;
  logic [7:0]  out_intensity;
  logic        out_point_valid;
  logic        out_last;

  frame_point_tracker tracker = new();
  int send_gap_pct = 0;
  int stall_pct    = 0;
  int bytes_sent   = 0;
  int cycles       = 0;

  lidar_frame_parser_crc8 dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_degree      (out_degree),
    .out_distance    (out_distance),
    .out_intensity   (out_intensity),
    .out_point_valid (out_point_valid),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: check accepted transactions, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_point({out_degree, out_distance, out_intensity,
                           out_point_valid, out_last});
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function void set_phase(phase_t ph);
    case (ph)
      PH_FLOW:       begin send_gap_pct = 0;  stall_pct = 0;  end
      PH_SEND_IDLE:  begin send_gap_pct = 85; stall_pct = 0;  end
      PH_RECV_STALL: begin send_gap_pct = 0;  stall_pct = 85; end
      default:       begin send_gap_pct = 23; stall_pct = 23; end
    endcase
  endfunction

  // Offer one byte, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b);
    // idling phases rotate every few dozen bytes
    set_phase(phase_t'((bytes_sent / PHASE_BYTES) % 4));
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    tracker.take_byte(b);
    bytes_sent++;
  endtask

  function automatic logic [15:0] rand_angle();
    if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, 35999));
  endfunction

  // Build a full frame with a correct or corrupted CRC and send it
  task automatic send_frame(input logic [15:0] start_a, input logic [15:0] end_a,
                            input fill_t fill, input bit bad_crc);
    logic [7:0]  fb [FRAME_BYTES];
    logic [7:0]  crc;
    logic [15:0] d;
    logic [7:0]  it;
    fb[0] = HDR_BYTE;
    fb[1] = VER_BYTE;
    fb[2] = 8'($urandom_range(0, 255));
    fb[3] = 8'($urandom_range(0, 255));
    fb[POS_START_LO] = start_a[7:0];
    fb[POS_START_HI] = start_a[15:8];
    for (int i = 0; i < POINTS_PER_FRAME; i++) begin
      case (fill)
        FILL_ZERO: begin d = 16'h0000; it = 8'($urandom_range(0, 255)); end
        FILL_MAX:  begin d = 16'hFFFF; it = 8'hFF; end
        default: begin
          d  = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom_range(0, 65535));
          it = 8'($urandom_range(0, 255));
        end
      endcase
      fb[POS_PT_BASE + 3 * i]     = d[7:0];
      fb[POS_PT_BASE + 3 * i + 1] = d[15:8];
      fb[POS_PT_BASE + 3 * i + 2] = it;
    end
    fb[POS_END_LO] = end_a[7:0];
    fb[POS_END_HI] = end_a[15:8];
    fb[44] = 8'($urandom_range(0, 255));
    fb[45] = 8'($urandom_range(0, 255));
    crc = 8'h00;
    for (int k = 0; k < FRAME_BYTES - 1; k++) crc = tracker.crc_step(crc, fb[k]);
    fb[POS_CRC] = bad_crc ? (crc ^ 8'($urandom_range(1, 255))) : crc;
    for (int k = 0; k < FRAME_BYTES; k++) send_byte(fb[k]);
  endtask

  initial begin
    int    pick;
    logic [7:0] b;
    set_phase(PH_FLOW);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: stray bytes, a repeated header, then edge-case frames
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(VER_BYTE);
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    send_frame(16'd0, 16'd3300, FILL_MAX, 1'b0);
    // end angle wrapped past zero, all points invalid
    send_frame(16'd35000, 16'd1000, FILL_ZERO, 1'b0);
    // start far above end: negative step
    send_frame(16'hFFFF, 16'h0000, FILL_MIXED, 1'b0);
    send_frame(16'd12345, 16'd12345, FILL_MIXED, 1'b0);
    send_frame(16'd100, 16'd3000, FILL_MAX, 1'b1);
    // header followed by a wrong second byte
    send_byte(HDR_BYTE);
    send_byte(8'h00);
    send_frame(16'h0000, 16'hFFFF, FILL_MIXED, 1'b0);
    send_frame(16'hFFFF, 16'hFFFF, FILL_ZERO, 1'b0);

    // Random: mostly well-formed frames, some bad CRCs, noise and broken headers
    while (bytes_sent < BYTE_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(rand_angle(), rand_angle(), FILL_MIXED, 1'b0);
      end else if (pick < 80) begin
        send_frame(rand_angle(), rand_angle(), FILL_MIXED, 1'b1);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(HDR_BYTE);
        do b = 8'($urandom_range(0, 255)); while (b == VER_BYTE);
        send_byte(b);
      end
    end
    in_valid <= 1'b0;

    // Drain
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lfp_pkg.sv
rtl/lfp_front.sv
rtl/lfp_queue.sv
rtl/lfp_back.sv
rtl/lidar_frame_parser_crc8.sv
verif/lidar_frame_parser_crc8_test.sv
